// ----- rtl/prt_pkg.sv -----
`default_nettype none
package prt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;

   localparam int SERIAL_W   = 32;
   localparam int TIME_W     = 64;
   localparam int MSG_TYPE_W = 8;

   typedef enum logic [1:0] {
      MODE_WAIT  = 2'd0,
      MODE_REPLY = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_INSERTED     = 3'd0,
      ST_REPLACED     = 3'd1,
      ST_FULL         = 3'd2,
      ST_NOT_REPLY    = 3'd3,
      ST_NOT_FOUND    = 3'd4,
      ST_MATCHED      = 3'd5,
      ST_EXPIRED      = 3'd6,
      ST_NONE_EXPIRED = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH,
      FSM_EMIT
   } fsm_type;

   // one table slot as it sits in the memory
   typedef struct packed {
      logic                fatal;
      logic [TIME_W-1:0]   deadline;
      logic [SERIAL_W-1:0] serial;
   } entry_type;

   // one result beat
   typedef struct packed {
      status_type            status;
      logic [SERIAL_W-1:0]   serial;
      logic                  entry_fatal;
      logic                  fatal_seen;
      logic [MSG_TYPE_W-1:0] error_type;
      logic                  last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/prt_store.sv -----
`default_nettype none
module prt_store #(
   parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEFAULT,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire prt_pkg::entry_type wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output prt_pkg::entry_type      rd_data
);

   prt_pkg::entry_type mem [TABLE_DEPTH];
   prt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/prt_obuf.sv -----
`default_nettype none
module prt_obuf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire prt_pkg::rsp_type push_data,
   output logic                  space,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output prt_pkg::rsp_type      out_data
);

   logic             valid_ff;
   logic             valid_in;
   prt_pkg::rsp_type data_ff;

   // a held beat leaving this cycle frees the slot
   assign space    = !valid_ff || out_ready;
   assign valid_in = (push && space) || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && space) begin
         data_ff <= push_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ----- rtl/prt_ctrl.sv -----
`default_nettype none
module prt_ctrl #(
   parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEFAULT,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // item side
   input  wire logic                              item_valid,
   output logic                                   item_ready,
   input  wire prt_pkg::mode_type                 item_mode,
   input  wire logic [prt_pkg::SERIAL_W-1:0]      item_serial,
   input  wire logic [prt_pkg::TIME_W-1:0]        item_deadline,
   input  wire logic                              item_fatal,
   input  wire logic                              item_reply,
   input  wire logic [prt_pkg::TIME_W-1:0]        item_now,
   input  wire logic [prt_pkg::MSG_TYPE_W-1:0]    timeout_type,
   // memory side
   output logic                                   wr_en,
   output logic [AW-1:0]                          wr_addr,
   output prt_pkg::entry_type                     wr_data,
   output logic                                   rd_en,
   output logic [AW-1:0]                          rd_addr,
   input  wire prt_pkg::entry_type                rd_data,
   // result side
   output logic                                   res_push,
   output prt_pkg::rsp_type                       res_data,
   input  wire logic                              res_space
);

   prt_pkg::fsm_type  state_ff, state_in;
   prt_pkg::mode_type mode_ff, mode_in;

   logic [prt_pkg::SERIAL_W-1:0] serial_ff, serial_in;
   logic [prt_pkg::TIME_W-1:0]   deadline_ff, deadline_in;
   logic                         fatal_ff, fatal_in;
   logic                         reply_ff, reply_in;
   logic [prt_pkg::TIME_W-1:0]   now_ff, now_in;

   logic                   select_ff, select_in;
   logic [CW-1:0]          iss_ff, iss_in;
   logic                   pv_ff, pv_in;
   logic [AW-1:0]          pa_ff, pa_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0] hit_ff, hit_in;
   logic [CW-1:0]          hit_cnt_ff, hit_cnt_in;

   logic          match_ff, match_in;
   logic [AW-1:0] match_slot_ff, match_slot_in;
   logic          match_fatal_ff, match_fatal_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_slot_ff, free_slot_in;

   logic                         best_ff, best_in;
   logic [AW-1:0]                best_slot_ff, best_slot_in;
   logic [prt_pkg::SERIAL_W-1:0] best_serial_ff, best_serial_in;
   logic                         best_fatal_ff, best_fatal_in;
   logic                         seen_ff, seen_in;

   prt_pkg::rsp_type res_ff, res_in;

   logic scan_done;
   logic entry_live;
   logic entry_hit;

   assign scan_done  = (iss_ff == CW'(TABLE_DEPTH));
   assign entry_live = valid_ff[pa_ff];
   assign entry_hit  = entry_live && (rd_data.deadline != '0) && (now_ff >= rd_data.deadline);

   assign item_ready = (state_ff == prt_pkg::FSM_IDLE);
   assign res_push   = (state_ff == prt_pkg::FSM_EMIT);
   assign res_data   = res_ff;

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      serial_in      = serial_ff;
      deadline_in    = deadline_ff;
      fatal_in       = fatal_ff;
      reply_in       = reply_ff;
      now_in         = now_ff;
      select_in      = select_ff;
      iss_in         = iss_ff;
      pv_in          = 1'b0;
      pa_in          = pa_ff;
      valid_in       = valid_ff;
      hit_in         = hit_ff;
      hit_cnt_in     = hit_cnt_ff;
      match_in       = match_ff;
      match_slot_in  = match_slot_ff;
      match_fatal_in = match_fatal_ff;
      free_in        = free_ff;
      free_slot_in   = free_slot_ff;
      best_in        = best_ff;
      best_slot_in   = best_slot_ff;
      best_serial_in = best_serial_ff;
      best_fatal_in  = best_fatal_ff;
      seen_in        = seen_ff;
      res_in         = res_ff;
      wr_en          = 1'b0;
      wr_addr        = match_slot_ff;
      wr_data        = '{fatal: fatal_ff, deadline: deadline_ff, serial: serial_ff};
      rd_en          = 1'b0;
      rd_addr        = iss_ff[AW-1:0];

      unique case (state_ff)
         prt_pkg::FSM_IDLE: begin
            if (item_valid) begin
               mode_in     = item_mode;
               serial_in   = item_serial;
               deadline_in = item_deadline;
               fatal_in    = item_fatal;
               reply_in    = item_reply;
               now_in      = item_now;
               select_in   = 1'b0;
               iss_in      = '0;
               hit_cnt_in  = '0;
               match_in    = 1'b0;
               free_in     = 1'b0;
               best_in     = 1'b0;
               seen_in     = 1'b0;
               if (item_mode == prt_pkg::MODE_NONE) begin
                  state_in = prt_pkg::FSM_IDLE;
               end else if (item_mode == prt_pkg::MODE_REPLY && !item_reply) begin
                  state_in = prt_pkg::FSM_FINISH;
               end else begin
                  state_in = prt_pkg::FSM_SCAN;
               end
            end
         end

         prt_pkg::FSM_SCAN: begin
            // issue one read a cycle, look at the data in the cycle after
            if (!scan_done) begin
               rd_en  = 1'b1;
               iss_in = iss_ff + CW'(1);
               pv_in  = 1'b1;
               pa_in  = iss_ff[AW-1:0];
            end else begin
               state_in = prt_pkg::FSM_FINISH;
            end
            if (pv_ff) begin
               if (mode_ff == prt_pkg::MODE_TICK) begin
                  if (!select_ff) begin
                     hit_in[pa_ff] = entry_hit;
                     if (entry_hit) begin
                        hit_cnt_in = hit_cnt_ff + CW'(1);
                     end
                  end else if (hit_ff[pa_ff] &&
                               (!best_ff || rd_data.serial < best_serial_ff)) begin
                     best_in        = 1'b1;
                     best_slot_in   = pa_ff;
                     best_serial_in = rd_data.serial;
                     best_fatal_in  = rd_data.fatal;
                  end
               end else begin
                  if (entry_live && rd_data.serial == serial_ff) begin
                     match_in       = 1'b1;
                     match_slot_in  = pa_ff;
                     match_fatal_in = rd_data.fatal;
                  end
                  if (!entry_live && !free_ff) begin
                     free_in      = 1'b1;
                     free_slot_in = pa_ff;
                  end
               end
            end
         end

         prt_pkg::FSM_FINISH: begin
            state_in       = prt_pkg::FSM_EMIT;
            res_in         = '0;
            res_in.serial  = serial_ff;
            res_in.last    = 1'b1;
            if (mode_ff == prt_pkg::MODE_WAIT) begin
               if (match_ff) begin
                  res_in.status           = prt_pkg::ST_REPLACED;
                  wr_en                   = 1'b1;
                  wr_addr                 = match_slot_ff;
                  valid_in[match_slot_ff] = 1'b1;
               end else if (free_ff) begin
                  res_in.status          = prt_pkg::ST_INSERTED;
                  wr_en                  = 1'b1;
                  wr_addr                = free_slot_ff;
                  valid_in[free_slot_ff] = 1'b1;
               end else begin
                  res_in.status = prt_pkg::ST_FULL;
               end
            end else if (mode_ff == prt_pkg::MODE_REPLY) begin
               if (!reply_ff) begin
                  res_in.status = prt_pkg::ST_NOT_REPLY;
               end else if (match_ff) begin
                  res_in.status           = prt_pkg::ST_MATCHED;
                  res_in.entry_fatal      = match_fatal_ff;
                  valid_in[match_slot_ff] = 1'b0;
               end else begin
                  res_in.status = prt_pkg::ST_NOT_FOUND;
               end
            end else if (!select_ff) begin
               if (hit_cnt_ff == '0) begin
                  res_in.status = prt_pkg::ST_NONE_EXPIRED;
                  res_in.serial = '0;
               end else begin
                  // expired entries found: pick them out lowest serial first
                  state_in  = prt_pkg::FSM_SCAN;
                  select_in = 1'b1;
                  iss_in    = '0;
                  best_in   = 1'b0;
               end
            end else begin
               res_in.status          = prt_pkg::ST_EXPIRED;
               res_in.serial          = best_serial_ff;
               res_in.entry_fatal     = best_fatal_ff;
               res_in.fatal_seen      = seen_ff || best_fatal_ff;
               res_in.error_type      = timeout_type;
               res_in.last            = (hit_cnt_ff == CW'(1));
               seen_in                = seen_ff || best_fatal_ff;
               valid_in[best_slot_ff] = 1'b0;
               hit_in[best_slot_ff]   = 1'b0;
               hit_cnt_in             = hit_cnt_ff - CW'(1);
            end
         end

         prt_pkg::FSM_EMIT: begin
            if (res_space) begin
               if (res_ff.last) begin
                  state_in = prt_pkg::FSM_IDLE;
               end else begin
                  state_in = prt_pkg::FSM_SCAN;
                  iss_in   = '0;
                  best_in  = 1'b0;
               end
            end
         end

         default: begin
            state_in = prt_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= prt_pkg::FSM_IDLE;
         pv_ff      <= 1'b0;
         valid_ff   <= '0;
         hit_ff     <= '0;
         hit_cnt_ff <= '0;
         select_ff  <= 1'b0;
         match_ff   <= 1'b0;
         free_ff    <= 1'b0;
         best_ff    <= 1'b0;
         seen_ff    <= 1'b0;
         iss_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         pv_ff      <= pv_in;
         valid_ff   <= valid_in;
         hit_ff     <= hit_in;
         hit_cnt_ff <= hit_cnt_in;
         select_ff  <= select_in;
         match_ff   <= match_in;
         free_ff    <= free_in;
         best_ff    <= best_in;
         seen_ff    <= seen_in;
         iss_ff     <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      serial_ff      <= serial_in;
      deadline_ff    <= deadline_in;
      fatal_ff       <= fatal_in;
      reply_ff       <= reply_in;
      now_ff         <= now_in;
      pa_ff          <= pa_in;
      match_slot_ff  <= match_slot_in;
      match_fatal_ff <= match_fatal_in;
      free_slot_ff   <= free_slot_in;
      best_slot_ff   <= best_slot_in;
      best_serial_ff <= best_serial_in;
      best_fatal_ff  <= best_fatal_in;
      res_ff         <= res_in;
   end

endmodule
`default_nettype wire

// ----- rtl/pending_reply_tracker_core.sv -----
`default_nettype none
// wait and marked reply beats: one table pass at one read a cycle, then the result goes to the
//   output register; an unmarked reply skips the pass, the unused mode gives no result
// tick beats: a marking pass, then one selection pass per expired entry,
//   or a none-expired result when nothing expired
// the next beat is taken in the cycle after the last result enters the output register
// reset: slots empty, timeout message type 0, no clearing pass, contents unknown until written
module pending_reply_tracker_core #(
   parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_mode,
   input  wire logic [prt_pkg::SERIAL_W-1:0]      req_serial,
   input  wire logic [prt_pkg::TIME_W-1:0]        req_deadline_us,
   input  wire logic                              req_is_fatal,
   input  wire logic                              req_is_reply,
   input  wire logic [prt_pkg::TIME_W-1:0]        req_now_us,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [2:0]                             rsp_status,
   output logic [prt_pkg::SERIAL_W-1:0]           rsp_result_serial,
   output logic                                   rsp_entry_fatal,
   output logic                                   rsp_fatal_seen,
   output logic [prt_pkg::MSG_TYPE_W-1:0]         rsp_error_type,
   output logic                                   rsp_last,
   // timeout message type register
   input  wire logic                              csr_wr_en,
   input  wire logic [prt_pkg::MSG_TYPE_W-1:0]    csr_wr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // message type stamped on every expired beat
   logic [prt_pkg::MSG_TYPE_W-1:0] timeout_type_ff;

   // table memory access
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   prt_pkg::entry_type wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   prt_pkg::entry_type rd_data;

   // result hand-off into the output register
   logic             res_push;
   prt_pkg::rsp_type res_data;
   logic             res_space;
   prt_pkg::rsp_type out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_type_ff <= '0;
      end else if (csr_wr_en) begin
         timeout_type_ff <= csr_wr_data;
      end
   end

   // serial, deadline and fatal flag of every slot live in one memory word
   prt_store #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer: slot valid bits, expiry marks, the scan passes and the result build
   prt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (req_valid),
      .item_ready    (req_ready),
      .item_mode     (prt_pkg::mode_type'(req_mode)),
      .item_serial   (req_serial),
      .item_deadline (req_deadline_us),
      .item_fatal    (req_is_fatal),
      .item_reply    (req_is_reply),
      .item_now      (req_now_us),
      .timeout_type  (timeout_type_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .res_push      (res_push),
      .res_data      (res_data),
      .res_space     (res_space)
   );

   // output register keeps the response side apart from the sequencer
   prt_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .space     (res_space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_status        = out_data.status;
   assign rsp_result_serial = out_data.serial;
   assign rsp_entry_fatal   = out_data.entry_fatal;
   assign rsp_fatal_seen    = out_data.fatal_seen;
   assign rsp_error_type    = out_data.error_type;
   assign rsp_last          = out_data.last;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import prt_pkg::*;

   localparam int DEPTH         = TABLE_DEPTH_DEFAULT;
   // a full table pass plus margin, taken a few times over
   localparam int SETTLE_CYCLES = 4 * (DEPTH + 4);
   // receiver back-pressure window, in monitor cycles
   localparam int HOLD_FROM     = 1500;
   localparam int HOLD_TO       = 2100;
   // stretch with no idling on either side
   localparam int CALM_FROM     = 5000;
   localparam int CALM_TO       = 8000;
   localparam int IDLE_PCT      = 26;
   localparam int RANDOM_ITEMS  = 89;
   localparam int PHASES        = 5;

   // one request beat as the driver presents it
   typedef struct {
      mode_type            mode;
      logic [SERIAL_W-1:0] serial;
      logic [TIME_W-1:0]   deadline;
      logic                fatal;
      logic                reply;
      logic [TIME_W-1:0]   now;
   } request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_mode = MODE_NONE;
   logic [SERIAL_W-1:0]   req_serial = '0;
   logic [TIME_W-1:0]     req_deadline_us = '0;
   logic                  req_is_fatal = 1'b0;
   logic                  req_is_reply = 1'b0;
   logic [TIME_W-1:0]     req_now_us = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_status;
   logic [SERIAL_W-1:0]   rsp_result_serial;
   logic                  rsp_entry_fatal;
   logic                  rsp_fatal_seen;
   logic [MSG_TYPE_W-1:0] rsp_error_type;
   logic                  rsp_last;
   logic                  csr_wr_en = 1'b0;
   logic [MSG_TYPE_W-1:0] csr_wr_data = '0;

   // stimulus waiting for the driver, and results the table owes us
   request_type request_q[$];
   request_type cur_req;
   rsp_type     due_results[$];
   int          mismatches = 0;
   int          drv_cycle  = 0;
   int          mon_cycle  = 0;

   // shadow of the tracker table and its message type register
   bit                  slot_used     [DEPTH];
   bit [SERIAL_W-1:0]   slot_serial   [DEPTH];
   bit [TIME_W-1:0]     slot_deadline [DEPTH];
   bit                  slot_fatal    [DEPTH];
   bit [MSG_TYPE_W-1:0] msg_type_shadow = '0;

   // random stimulus shaping
   bit [SERIAL_W-1:0] serial_pool[$];
   bit [TIME_W-1:0]   epoch_us;

   pending_reply_tracker_core #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_serial       (req_serial),
      .req_deadline_us  (req_deadline_us),
      .req_is_fatal     (req_is_fatal),
      .req_is_reply     (req_is_reply),
      .req_now_us       (req_now_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_serial(rsp_result_serial),
      .rsp_entry_fatal  (rsp_entry_fatal),
      .rsp_fatal_seen   (rsp_fatal_seen),
      .rsp_error_type   (rsp_error_type),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // generous ceiling on the whole run
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------
   // shadow table: update on an accepted beat, queue the results owed
   // ---------------------------------------------------------------
   function automatic int lookup_serial(bit [SERIAL_W-1:0] s);
      for (int k = 0; k < DEPTH; k++)
         if (slot_used[k] && slot_serial[k] == s) return k;
      return -1;
   endfunction

   function automatic void apply_to_table(request_type it);
      rsp_type r;
      int      slot;
      int      best;
      int      n_hit;
      bit      hit [DEPTH];
      bit      seen;
      r        = '0;
      r.serial = it.serial;
      r.last   = 1'b1;
      case (it.mode)
         MODE_WAIT: begin
            // same serial replaces, else lowest free slot
            slot     = lookup_serial(it.serial);
            r.status = ST_REPLACED;
            if (slot < 0) begin
               r.status = ST_INSERTED;
               for (int k = DEPTH - 1; k >= 0; k--)
                  if (!slot_used[k]) slot = k;
            end
            if (slot < 0) begin
               r.status = ST_FULL;
            end else begin
               slot_used[slot]     = 1'b1;
               slot_serial[slot]   = it.serial;
               slot_deadline[slot] = it.deadline;
               slot_fatal[slot]    = it.fatal;
            end
            due_results.push_back(r);
         end
         MODE_REPLY: begin
            if (!it.reply) begin
               r.status = ST_NOT_REPLY;
            end else begin
               slot = lookup_serial(it.serial);
               if (slot < 0) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  r.status        = ST_MATCHED;
                  r.entry_fatal   = slot_fatal[slot];
                  slot_used[slot] = 1'b0;
               end
            end
            due_results.push_back(r);
         end
         MODE_TICK: begin
            // a zero deadline never expires
            n_hit = 0;
            for (int k = 0; k < DEPTH; k++) begin
               hit[k] = slot_used[k] && slot_deadline[k] != '0 && it.now >= slot_deadline[k];
               if (hit[k]) n_hit++;
            end
            if (n_hit == 0) begin
               r.status = ST_NONE_EXPIRED;
               r.serial = '0;
               due_results.push_back(r);
            end else begin
               // expired entries leave in ascending serial order
               seen = 1'b0;
               for (int j = 0; j < n_hit; j++) begin
                  best = -1;
                  for (int k = 0; k < DEPTH; k++)
                     if (hit[k] && (best < 0 || slot_serial[k] < slot_serial[best])) best = k;
                  hit[best]       = 1'b0;
                  slot_used[best] = 1'b0;
                  seen            = seen | slot_fatal[best];
                  r.status        = ST_EXPIRED;
                  r.serial        = slot_serial[best];
                  r.entry_fatal   = slot_fatal[best];
                  r.fatal_seen    = seen;
                  r.error_type    = msg_type_shadow;
                  r.last          = (j == n_hit - 1);
                  due_results.push_back(r);
               end
            end
         end
         default: begin
            // unused mode: no result, table untouched
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // driver: present queued beats, idle at random except in the calm stretch
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      request_type nxt;
      bit          calm;
      bit          send;
      if (reset) begin
         req_valid <= 1'b0;
         drv_cycle <= 0;
      end else begin
         drv_cycle <= drv_cycle + 1;
         calm = drv_cycle >= CALM_FROM && drv_cycle < CALM_TO;
         if (req_valid && req_ready) apply_to_table(cur_req);
         // only move on once the current beat is taken
         if (!req_valid || req_ready) begin
            send = request_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT);
            if (send) begin
               nxt             = request_q.pop_front();
               cur_req         <= nxt;
               req_valid       <= 1'b1;
               req_mode        <= nxt.mode;
               req_serial      <= nxt.serial;
               req_deadline_us <= nxt.deadline;
               req_is_fatal    <= nxt.fatal;
               req_is_reply    <= nxt.reply;
               req_now_us      <= nxt.now;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: check each result beat against the oldest owed result
   // ---------------------------------------------------------------
   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         mon_cycle <= 0;
      end else begin
         mon_cycle <= mon_cycle + 1;
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $display("%0t mismatch unexpected beat: expected none actual status %0h serial %0h",
                        $time, rsp_status, rsp_result_serial);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("result_serial", want.serial, rsp_result_serial);
               check_field("entry_fatal", want.entry_fatal, rsp_entry_fatal);
               check_field("fatal_seen", want.fatal_seen, rsp_fatal_seen);
               check_field("error_type", want.error_type, rsp_error_type);
               check_field("last", want.last, rsp_last);
            end
         end
         // long hold-off fills the block and backs up the request side
         if (mon_cycle >= HOLD_FROM && mon_cycle < HOLD_TO)
            rsp_ready <= 1'b0;
         else if (mon_cycle >= CALM_FROM && mon_cycle < CALM_TO)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= $urandom_range(99) >= IDLE_PCT;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   function automatic void push_req(mode_type m, logic [SERIAL_W-1:0] s,
                                    logic [TIME_W-1:0] d, logic f, logic rp,
                                    logic [TIME_W-1:0] n);
      request_type it;
      it.mode     = m;
      it.serial   = s;
      it.deadline = d;
      it.fatal    = f;
      it.reply    = rp;
      it.now      = n;
      request_q.push_back(it);
   endfunction

   function automatic bit [SERIAL_W-1:0] pick_serial();
      if ($urandom_range(9) == 0) return $urandom;
      return serial_pool[$urandom_range(serial_pool.size() - 1)];
   endfunction

   function automatic bit [TIME_W-1:0] pick_deadline();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 13) return '1;
      if (roll < 18) return {$urandom, $urandom};
      return epoch_us + $urandom_range(1, 400);
   endfunction

   function automatic bit [TIME_W-1:0] pick_now();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return '1;
      if (roll < 10) return {$urandom, $urandom};
      return epoch_us + $urandom_range(0, 400);
   endfunction

   // mostly well-formed bursts (fill, reply, tick) with some noise mixed in
   function automatic void add_random_phase(int n_items);
      int          count;
      int          roll;
      int          len;
      request_type it;
      count = 0;
      serial_pool.delete();
      serial_pool.push_back('0);
      serial_pool.push_back('1);
      repeat (22) serial_pool.push_back(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom);
      epoch_us = {$urandom, $urandom} >> $urandom_range(4, 60);
      while (count < n_items) begin
         roll = $urandom_range(99);
         len  = (roll < 45) ? $urandom_range(2, 10) :
                (roll < 70) ? $urandom_range(1, 5) :
                (roll < 90) ? 1 : $urandom_range(1, 3);
         repeat (len) begin
            // irrelevant fields carry noise
            it.mode     = MODE_WAIT;
            it.serial   = $urandom;
            it.deadline = {$urandom, $urandom};
            it.fatal    = $urandom_range(1);
            it.reply    = $urandom_range(1);
            it.now      = {$urandom, $urandom};
            if (roll < 45) begin
               it.serial   = pick_serial();
               it.deadline = pick_deadline();
            end else if (roll < 70) begin
               it.mode   = MODE_REPLY;
               it.serial = pick_serial();
               it.reply  = $urandom_range(99) < 85;
            end else if (roll < 90) begin
               it.mode = MODE_TICK;
               it.now  = pick_now();
               if ($urandom_range(99) < 40) epoch_us += $urandom_range(50, 300);
            end else begin
               it.mode = mode_type'($urandom_range(3));
            end
            request_q.push_back(it);
            if (it.mode != MODE_NONE) count++;
         end
      end
   endfunction

   // wait for every beat to be taken and every result to come back
   task automatic settle();
      while (request_q.size() != 0 || req_valid || due_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : run_test
      logic [MSG_TYPE_W-1:0] msg_plan [PHASES];
      msg_plan[0] = 8'hFF;
      msg_plan[1] = $urandom;
      msg_plan[2] = 8'h00;
      msg_plan[3] = $urandom;
      msg_plan[4] = 8'h80;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty tick, replace, reply corner cases, unused mode
      push_req(MODE_TICK, $urandom, {$urandom, $urandom}, 1'b0, 1'b0, '0);
      push_req(MODE_WAIT, '0, '1, 1'b1, 1'b0, '0);
      push_req(MODE_WAIT, '1, '0, 1'b0, 1'b1, '1);
      push_req(MODE_WAIT, '0, 64'd5, 1'b1, 1'b0, '0);
      push_req(MODE_REPLY, '1, '0, 1'b1, 1'b0, '0);
      push_req(MODE_REPLY, 32'h1234, '0, 1'b0, 1'b1, '0);
      push_req(MODE_NONE, $urandom, {$urandom, $urandom}, 1'b1, 1'b1, {$urandom, $urandom});
      // fill the table with descending serials so expiry has to sort
      for (int i = 14; i >= 1; i--)
         push_req(MODE_WAIT, i, 64'd100 + i, (i % 3) == 0, 1'b0, '0);
      push_req(MODE_WAIT, 32'hABCD, 64'd7, 1'b1, 1'b1, '0);
      // partial expiry, then everything with a nonzero deadline
      push_req(MODE_TICK, '0, '0, 1'b0, 1'b0, 64'd107);
      push_req(MODE_TICK, '0, '0, 1'b0, 1'b0, '1);
      push_req(MODE_REPLY, '1, '0, 1'b0, 1'b1, '0);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         // register written only with the block drained
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= msg_plan[p];
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         msg_type_shadow = msg_plan[p];
         @(negedge clock);
         add_random_phase(RANDOM_ITEMS);
      end
      settle();

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/prt_pkg.sv
rtl/prt_store.sv
rtl/prt_obuf.sv
rtl/prt_ctrl.sv
rtl/pending_reply_tracker_core.sv
dv/testbench.sv
